[rtl/assert_macros.svh]
// Assertion macros used by the checker file, bmh_checker.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, off while reset is low.
`define BMH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Same, for a property whose consequent is checked in the cycle after the antecedent.
`define BMH_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bmh_pkg.sv]
// Shared types and constants for the binary min-heap unit.
// No dependencies; imported by the RAM-using top level and the checker.
package bmh_pkg;

    localparam int BMH_DEPTH = 128;
    localparam int VAL_W     = 32;
    localparam int CAP_W     = 8;
    localparam int CNT_OUT_W = 8;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

    typedef enum logic {
        FN_INSERT = 1'b0,
        FN_DELETE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_TOP,
        S_DN_LAST,
        S_DN_CHK,
        S_DN_L,
        S_DN_R,
        S_DN_CMP
    } t_state;

    typedef struct packed {
        t_func                    func;
        logic signed [VAL_W-1:0]  value;
    } t_heap_in;

    typedef struct packed {
        logic signed [VAL_W-1:0]  min_value;
        t_status                  status;
        logic [CNT_OUT_W-1:0]     entry_count_out;
    } t_heap_out;

    localparam logic signed [VAL_W-1:0] EMPTY_VALUE = -32'sd1;

endpackage

[rtl/binary_min_heap_unit.sv]
// Binary min-heap priority queue: top level with sequencer and heap RAM.
// Depends on bmh_pkg and bmh_ram.
//
// One transaction at a time: start is taken while busy is low, and the
// result appears on o_result for a single cycle flagged by o_done. The
// receiver cannot stall, so o_result must be captured on that cycle. A
// refused insert (heap full) or delete (heap empty) answers on the next
// cycle. Everything else is paced by the heap RAM's single read port and
// its registered read. An insert reads each parent, then compares and
// writes, moving the parent down into the hole or the item into it; an
// item that climbs all the way is written at the root. A delete-minimum
// fetches root and last entry, then on each level descended reads the left
// child, reads the right child if there is one, then compares and writes;
// it ends with a final write. With at most DEPTH-1 entries left the entry
// descends at most log2(DEPTH)-1 levels. A new transaction may be started
// in the same cycle o_done is shown. Capacity is written through
// i_cfg_we/i_cfg_wdata (reset 128); the usable limit is the smaller of
// capacity and DEPTH, and lowering it below the current count keeps
// existing entries but refuses inserts. Heap RAM has no reset: only slots
// already written are ever read.
module binary_min_heap_unit #(
    parameter int DEPTH = bmh_pkg::BMH_DEPTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bmh_pkg::CAP_W-1:0]  i_cfg_wdata,
    input  logic                       start,
    input  bmh_pkg::t_heap_in          i_item,
    output logic                       busy,
    output logic                       o_done,
    output bmh_pkg::t_heap_out         o_result
);

    import bmh_pkg::*;

    // AW addresses the RAM (slot-1), CW holds a slot number 0..DEPTH.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [LW-1:0] DEPTH_L = LW'(DEPTH);

    // Control state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [CAP_W-1:0] r_cap;
    logic            r_done, n_done;

    // Working registers (payload, no reset)
    logic [CW-1:0]           r_pos, n_pos;     // hole being filled
    logic [CW-1:0]           r_kid, n_kid;     // smaller child so far
    logic signed [VAL_W-1:0] r_item, n_item;   // value being sifted
    logic signed [VAL_W-1:0] r_child, n_child; // value of r_kid
    logic signed [VAL_W-1:0] r_top, n_top;     // removed root
    t_heap_out               r_result, n_result;

    // RAM ports
    logic             w_we, w_re;
    logic [AW-1:0]    w_waddr, w_raddr;
    logic [VAL_W-1:0] w_wdata, w_rdata;
    logic signed [VAL_W-1:0] w_rval;

    // Helpers
    logic            w_accept;
    logic            w_full;
    logic [LW-1:0]   w_cnt_l, w_cap_l, w_limit;
    logic [CW:0]     w_two_pos;
    logic            w_has_l, w_has_r;
    logic [CW-1:0]   w_left, w_parent;
    logic [AW-1:0]   w_pos_addr;

    bmh_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rval   = $signed(w_rdata);
    assign w_accept = start && (r_state == S_IDLE);

    // limit = min(capacity, DEPTH)
    assign w_cnt_l  = LW'(r_cnt);
    assign w_cap_l  = LW'(r_cap);
    assign w_limit  = (w_cap_l < DEPTH_L) ? w_cap_l : DEPTH_L;
    assign w_full   = (w_cnt_l >= w_limit);

    assign w_two_pos  = {r_pos, 1'b0};
    assign w_has_l    = (w_two_pos <= {1'b0, r_cnt});
    assign w_left     = w_two_pos[CW-1:0];
    assign w_has_r    = (r_kid != r_cnt);
    assign w_parent   = r_pos >> 1;
    assign w_pos_addr = AW'(r_pos - CW'(1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.func == FN_INSERT) begin
                        if (!w_full) begin
                            n_state = S_UP_CHK;
                        end
                    end else if (r_cnt != '0) begin
                        n_state = S_DN_TOP;
                    end
                end
            end
            S_UP_CHK: begin
                n_state = (r_pos == CW'(1)) ? S_IDLE : S_UP_CMP;
            end
            S_UP_CMP: begin
                n_state = (w_rval > r_item) ? S_UP_CHK : S_IDLE;
            end
            S_DN_TOP:  n_state = S_DN_LAST;
            S_DN_LAST: n_state = S_DN_CHK;
            S_DN_CHK: begin
                n_state = w_has_l ? S_DN_L : S_IDLE;
            end
            S_DN_L: begin
                n_state = w_has_r ? S_DN_R : S_DN_CMP;
            end
            S_DN_R:    n_state = S_DN_CMP;
            S_DN_CMP: begin
                n_state = (r_item > r_child) ? S_DN_CHK : S_IDLE;
            end
            default:   n_state = S_IDLE;
        endcase
    end

    // Datapath, RAM access and result
    always_comb begin
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_kid    = r_kid;
        n_item   = r_item;
        n_child  = r_child;
        n_top    = r_top;
        n_done   = 1'b0;
        n_result = r_result;
        w_we     = 1'b0;
        w_waddr  = w_pos_addr;
        w_wdata  = r_item;
        w_re     = 1'b0;
        w_raddr  = w_pos_addr;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_item.func == FN_INSERT) begin
                        if (w_full) begin
                            n_done   = 1'b1;
                            n_result = '{min_value: '0, status: ST_FULL,
                                         entry_count_out: w_cnt_l[CNT_OUT_W-1:0]};
                        end else begin
                            n_item = i_item.value;
                            n_cnt  = r_cnt + CW'(1);
                            n_pos  = r_cnt + CW'(1);
                        end
                    end else if (r_cnt == '0) begin
                        n_done   = 1'b1;
                        n_result = '{min_value: EMPTY_VALUE, status: ST_EMPTY,
                                     entry_count_out: '0};
                    end else begin
                        // fetch root; remember last slot
                        w_re    = 1'b1;
                        w_raddr = '0;
                        n_pos   = r_cnt;
                        n_cnt   = r_cnt - CW'(1);
                    end
                end
            end
            S_UP_CHK: begin
                if (r_pos == CW'(1)) begin
                    w_we     = 1'b1;
                    n_done   = 1'b1;
                    n_result = '{min_value: '0, status: ST_DONE,
                                 entry_count_out: w_cnt_l[CNT_OUT_W-1:0]};
                end else begin
                    w_re    = 1'b1;
                    w_raddr = AW'(w_parent - CW'(1));
                end
            end
            S_UP_CMP: begin
                w_we = 1'b1;
                if (w_rval > r_item) begin
                    // parent moves down into the hole
                    w_wdata = w_rdata;
                    n_pos   = w_parent;
                end else begin
                    n_done   = 1'b1;
                    n_result = '{min_value: '0, status: ST_DONE,
                                 entry_count_out: w_cnt_l[CNT_OUT_W-1:0]};
                end
            end
            S_DN_TOP: begin
                n_top  = w_rval;
                w_re   = 1'b1;      // last entry, addressed by r_pos
            end
            S_DN_LAST: begin
                n_item = w_rval;
                n_pos  = CW'(1);
            end
            S_DN_CHK: begin
                if (w_has_l) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(w_left - CW'(1));
                    n_kid   = w_left;
                end else begin
                    w_we     = 1'b1;
                    n_done   = 1'b1;
                    n_result = '{min_value: r_top, status: ST_DONE,
                                 entry_count_out: w_cnt_l[CNT_OUT_W-1:0]};
                end
            end
            S_DN_L: begin
                n_child = w_rval;
                if (w_has_r) begin
                    w_re    = 1'b1;
                    w_raddr = AW'(r_kid);  // slot r_kid+1, minus one
                end
            end
            S_DN_R: begin
                // right child only if strictly smaller
                if (w_rval < r_child) begin
                    n_child = w_rval;
                    n_kid   = r_kid + CW'(1);
                end
            end
            S_DN_CMP: begin
                w_we = 1'b1;
                if (r_item > r_child) begin
                    w_wdata = r_child;
                    n_pos   = r_kid;
                end else begin
                    n_done   = 1'b1;
                    n_result = '{min_value: r_top, status: ST_DONE,
                                 entry_count_out: w_cnt_l[CNT_OUT_W-1:0]};
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_cap   <= CAP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_kid    <= n_kid;
        r_item   <= n_item;
        r_child  <= n_child;
        r_top    <= n_top;
        r_result <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[rtl/bmh_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module bmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [WIDTH-1:0]           i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/bmh_checker.sv]
// Port-level checker for binary_min_heap_unit, bound to the top level.
// Depends on bmh_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bmh_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       o_done,
    input bmh_pkg::t_heap_out         o_result
);

    import bmh_pkg::*;

    logic w_empty_res, w_empty_ok, w_full_res;

    assign w_empty_res = o_done && (o_result.status == ST_EMPTY);
    assign w_empty_ok  = (o_result.min_value == EMPTY_VALUE) &&
                         (o_result.entry_count_out == '0);
    assign w_full_res  = o_done && (o_result.status == ST_FULL);

    // A result always lands with the unit free to take the next transaction
    `BMH_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "result shown while busy")

    // Every accepted transaction either answers at once or occupies the unit
    `BMH_ASSERT_NEXT(a_accept_progress, i_clk, i_rst_n, start && !busy, busy || o_done, "lost")

    // Empty delete reports -1 and an empty heap
    `BMH_ASSERT(a_empty_fields, i_clk, i_rst_n, w_empty_res |-> w_empty_ok, "bad empty delete")

    // Refused insert reports zero value
    `BMH_ASSERT(a_full_fields, i_clk, i_rst_n, w_full_res |-> (o_result.min_value == '0), "bad")

endmodule

bind binary_min_heap_unit bmh_checker u_bmh_checker (.*);
